/* rtl/prt_pkg.sv */
// Shared types and constants for the packet reassembly tracker.
package prt_pkg;

  localparam int unsigned DefTableEntries = 16;
  localparam int unsigned DefMaxPackets   = 32;

  // Width used to compare packet indexes and totals without overflow
  localparam int unsigned CmpW = 7;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Request travelling down the row of entry cells
  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [4:0]  idx;
    logic [5:0]  tot;
    logic        hit;
    logic        complete;
    status_e     status;
    logic        free_found;
  } link_t;

  // Allocation write broadcast to all cells
  typedef struct packed {
    logic        we;
    logic [63:0] key;
    logic [4:0]  idx;
    logic [5:0]  tot;
  } alloc_t;

endpackage

/* rtl/prt_cell.sv */
// One table entry of the reassembly tracker, with its stage of the request chain.
module prt_cell #(
  parameter int unsigned MAX_PACKETS = prt_pkg::DefMaxPackets,
  parameter int unsigned IDX_W       = 4,
  parameter int unsigned CELL_ID     = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prt_pkg::link_t      link_i,
  input  logic [IDX_W-1:0]    free_idx_i,
  output prt_pkg::link_t      link_o,
  output logic [IDX_W-1:0]    free_idx_o,
  input  prt_pkg::alloc_t     wr_i,
  input  logic [IDX_W-1:0]    wr_idx_i
);

  localparam int unsigned CntW = $clog2(MAX_PACKETS + 1);

  logic                   valid_q, valid_d;
  logic [63:0]            key_q, key_d;
  logic [MAX_PACKETS-1:0] map_q, map_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        total_q, total_d;

  prt_pkg::link_t         link_q, link_d;
  logic                   link_vld_q;
  logic [IDX_W-1:0]       free_idx_q, free_idx_d;

  logic [MAX_PACKETS-1:0] req_bit;
  logic [MAX_PACKETS-1:0] wr_bit;
  logic                   match;

  assign req_bit = MAX_PACKETS'(1) << link_i.idx;
  assign wr_bit  = MAX_PACKETS'(1) << wr_i.idx;
  assign match   = link_i.valid && valid_q && !link_i.hit && (key_q == link_i.key);

  // Check and update the entry, note the first free entry, pass the request on
  always_comb begin
    valid_d    = valid_q;
    key_d      = key_q;
    map_d      = map_q;
    count_d    = count_q;
    total_d    = total_q;
    link_d     = link_i;
    free_idx_d = free_idx_i;

    if (match) begin
      link_d.hit = 1'b1;
      if (prt_pkg::CmpW'(link_i.idx) >= prt_pkg::CmpW'(total_q)) begin
        link_d.status = prt_pkg::ST_RANGE;
      end else if ((map_q & req_bit) != '0) begin
        link_d.status = prt_pkg::ST_DUP;
      end else begin
        map_d   = map_q | req_bit;
        count_d = count_q + CntW'(1);
        if (count_d == total_q) begin
          valid_d         = 1'b0;
          link_d.complete = 1'b1;
        end
      end
    end

    if (link_i.valid && !link_i.free_found && !valid_q) begin
      link_d.free_found = 1'b1;
      free_idx_d        = IDX_W'(CELL_ID);
    end

    // Allocate a new message here; a single-packet message leaves it free
    if (wr_i.we && (wr_idx_i == IDX_W'(CELL_ID))) begin
      valid_d = (wr_i.tot != 6'd1);
      key_d   = wr_i.key;
      map_d   = wr_bit;
      count_d = CntW'(1);
      total_d = CntW'(wr_i.tot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      link_vld_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      link_vld_q <= link_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    map_q      <= map_d;
    count_q    <= count_d;
    total_q    <= total_d;
    link_q     <= link_d;
    free_idx_q <= free_idx_d;
  end

  always_comb begin
    link_o       = link_q;
    link_o.valid = link_vld_q;
  end

  assign free_idx_o = free_idx_q;

endmodule

/* rtl/packet_reassembly_tracker.sv */
// Top level of the packet reassembly tracker: entry cell row, allocation and result register.
//
// Each accepted packet walks a row of TABLE_ENTRIES entry cells, one cell per cycle; every
// cell compares the message key, updates its received map on a hit and records the first
// free entry it sees. After the last cell the tail logic allocates a free entry on a miss
// and loads the result register. One packet is in flight at a time: the next is accepted
// in the cycle after the result is taken. Status 0 accepted, 1 duplicate, 2 table full,
// 3 index or total out of range; the echoed ids are zero unless the message completed.
module packet_reassembly_tracker #(
  parameter int unsigned TABLE_ENTRIES = prt_pkg::DefTableEntries,
  parameter int unsigned MAX_PACKETS   = prt_pkg::DefMaxPackets
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  app_id_i,
  input  logic [23:0] source_id_i,
  input  logic [31:0] msg_id_i,
  input  logic [4:0]  packet_index_i,
  input  logic [5:0]  packet_total_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        complete_o,
  output logic [1:0]  status_o,
  output logic [7:0]  done_app_id_o,
  output logic [23:0] done_source_id_o,
  output logic [31:0] done_msg_id_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  prt_pkg::link_t   links [TABLE_ENTRIES+1];
  logic [IdxW-1:0]  free_idx [TABLE_ENTRIES+1];
  prt_pkg::link_t   head;
  prt_pkg::alloc_t  alloc;
  prt_pkg::link_t   tail;

  logic             busy_q;
  logic             out_valid_q;
  logic             complete_q, complete_d;
  prt_pkg::status_e status_q, status_d;
  logic [63:0]      key_q;
  logic             range_bad;
  logic             in_acc, out_acc;

  assign in_acc     = in_valid_i && !busy_q;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign in_stall_o = busy_q;

  // Launch the request into the head of the row
  always_comb begin
    head            = '0;
    head.valid      = in_acc;
    head.key        = {app_id_i, source_id_i, msg_id_i};
    head.idx        = packet_index_i;
    head.tot        = packet_total_i;
    head.status     = prt_pkg::ST_OK;
  end
  assign links[0]    = head;
  assign free_idx[0] = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    prt_cell #(
      .MAX_PACKETS (MAX_PACKETS),
      .IDX_W       (IdxW),
      .CELL_ID     (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .link_i     (links[g]),
      .free_idx_i (free_idx[g]),
      .link_o     (links[g+1]),
      .free_idx_o (free_idx[g+1]),
      .wr_i       (alloc),
      .wr_idx_i   (free_idx[TABLE_ENTRIES])
    );
  end

  assign tail = links[TABLE_ENTRIES];

  assign range_bad = (tail.tot == 6'd0)
                  || (prt_pkg::CmpW'(tail.tot) > prt_pkg::CmpW'(MAX_PACKETS))
                  || (prt_pkg::CmpW'(tail.idx) >= prt_pkg::CmpW'(tail.tot));

  // Resolve the request at the tail: hit result, or allocate on a miss
  always_comb begin
    alloc      = '0;
    alloc.key  = tail.key;
    alloc.idx  = tail.idx;
    alloc.tot  = tail.tot;
    status_d   = prt_pkg::ST_OK;
    complete_d = 1'b0;
    if (tail.hit) begin
      status_d   = tail.status;
      complete_d = tail.complete;
    end else if (range_bad) begin
      status_d = prt_pkg::ST_RANGE;
    end else if (!tail.free_found) begin
      status_d = prt_pkg::ST_FULL;
    end else begin
      alloc.we   = tail.valid;
      complete_d = (tail.tot == 6'd1);
    end
  end

  // Hold one request in flight and the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (out_acc) begin
        busy_q <= 1'b0;
      end
      if (tail.valid) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail.valid) begin
      complete_q <= complete_d;
      status_q   <= status_d;
      key_q      <= complete_d ? tail.key : 64'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign complete_o       = complete_q;
  assign status_o         = status_q;
  assign done_app_id_o    = key_q[63:56];
  assign done_source_id_o = key_q[55:32];
  assign done_msg_id_o    = key_q[31:0];

`ifndef SYNTH
  a_out_needs_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> busy_q)
    else $error("result pending without a request in flight");

  a_tail_needs_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> (busy_q && !out_valid_q))
    else $error("request left the row while idle or with a result pending");

  a_complete_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && complete_q) |-> (status_q == prt_pkg::ST_OK))
    else $error("completion reported with an error status");

  a_echo_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !complete_q) |-> (key_q == 64'd0))
    else $error("echoed ids nonzero without completion");
`endif

endmodule

/* tb/reassembly_checker.sv */
// Reassembly checker: predicts each packet's result from a table of messages in flight.
`timescale 1ns / 100ps

module reassembly_checker #(
  parameter int unsigned TABLE_ENTRIES = prt_pkg::DefTableEntries,
  parameter int unsigned MAX_PACKETS   = prt_pkg::DefMaxPackets
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  app_id_i,
  input  logic [23:0] source_id_i,
  input  logic [31:0] msg_id_i,
  input  logic [4:0]  packet_index_i,
  input  logic [5:0]  packet_total_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        complete_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  done_app_id_i,
  input  logic [23:0] done_source_id_i,
  input  logic [31:0] done_msg_id_i,
  output int unsigned results_owed_o,
  output int unsigned mismatches_o
);

  typedef struct packed {
    logic             complete;
    prt_pkg::status_e status;
    logic [7:0]       app_id;
    logic [23:0]      source_id;
    logic [31:0]      msg_id;
  } outcome_t;

  // Messages in flight as the block should hold them
  logic        entry_live  [TABLE_ENTRIES];
  logic [63:0] entry_key   [TABLE_ENTRIES];
  logic [63:0] entry_map   [TABLE_ENTRIES];
  int unsigned entry_count [TABLE_ENTRIES];
  int unsigned entry_total [TABLE_ENTRIES];

  outcome_t    outcomes_due[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  // Look up the message, update its received map and say what the block answers
  function automatic outcome_t track_packet(logic [63:0] key, logic [4:0] idx,
                                            logic [5:0] tot);
    outcome_t res;
    int       slot;
    res        = '0;
    res.status = prt_pkg::ST_OK;
    slot       = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot < 0 && entry_live[i] && entry_key[i] == key) slot = i;
    end
    if (slot < 0) begin
      // a miss must carry a usable total before it may take an entry
      if (tot == 0 || tot > MAX_PACKETS || idx >= tot) begin
        res.status = prt_pkg::ST_RANGE;
        return res;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot < 0 && !entry_live[i]) slot = i;
      end
      if (slot < 0) begin
        res.status = prt_pkg::ST_FULL;
        return res;
      end
      entry_live[slot]  = 1'b1;
      entry_key[slot]   = key;
      entry_map[slot]   = '0;
      entry_count[slot] = 0;
      entry_total[slot] = tot;
    end else if (idx >= entry_total[slot]) begin
      // the total stored at allocation governs, not the one on this packet
      res.status = prt_pkg::ST_RANGE;
      return res;
    end
    if (entry_map[slot][idx]) begin
      res.status = prt_pkg::ST_DUP;
      return res;
    end
    entry_map[slot][idx] = 1'b1;
    entry_count[slot]++;
    // free the entry and echo the ids once the last packet is in
    if (entry_count[slot] == entry_total[slot]) begin
      entry_live[slot] = 1'b0;
      res.complete     = 1'b1;
      res.app_id       = key[63:56];
      res.source_id    = key[55:32];
      res.msg_id       = key[31:0];
    end
    return res;
  endfunction

  // Compare one result with the oldest outstanding prediction
  function automatic void check_result(outcome_t got);
    outcome_t exp;
    logic     bad;
    if (outcomes_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result %0d arrived with nothing outstanding: complete=%0d status=%0d",
                 $realtime, results_seen, got.complete, got.status);
    end else begin
      exp = outcomes_due.pop_front();
      bad = (got.complete  !== exp.complete)  || (got.status !== exp.status) ||
            (got.app_id    !== exp.app_id)    || (got.source_id !== exp.source_id) ||
            (got.msg_id    !== exp.msg_id);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result %0d mismatch", $realtime, results_seen);
          $display("  expected complete=%0d status=%0d ids=%h/%h/%h", exp.complete,
                   exp.status, exp.app_id, exp.source_id, exp.msg_id);
          $display("  actual   complete=%0d status=%0d ids=%h/%h/%h", got.complete,
                   got.status, got.app_id, got.source_id, got.msg_id);
        end
      end
    end
    results_seen++;
  endfunction

  // Predict on each accepted request, check on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) entry_live[i] = 1'b0;
      outcomes_due.delete();
      results_owed_o <= 0;
      mismatches_o   <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        outcomes_due.push_back(track_packet({app_id_i, source_id_i, msg_id_i},
                                            packet_index_i, packet_total_i));
      if (out_valid_i && !out_stall_i)
        check_result({complete_i, prt_pkg::status_e'(status_i), done_app_id_i,
                      done_source_id_i, done_msg_id_i});
      results_owed_o <= outcomes_due.size();
      mismatches_o   <= mismatches;
    end
  end

endmodule

/* tb/tb_packet_reassembly_tracker.sv */
// Testbench top for the packet reassembly tracker: clock, reset, packet stimulus and verdict.
`timescale 1ns / 100ps

module tb_packet_reassembly_tracker;

  localparam int unsigned TableEntries  = prt_pkg::DefTableEntries;
  localparam int unsigned MaxPackets    = prt_pkg::DefMaxPackets;
  localparam int unsigned RandomItems   = 2000;
  localparam int unsigned HoldOffCycles = 400;

  typedef struct packed {
    logic [63:0] key;
    logic [5:0]  total;
    logic [31:0] sent;
    logic [5:0]  left;
  } open_msg_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  app_id       = '0;
  logic [23:0] source_id    = '0;
  logic [31:0] msg_id       = '0;
  logic [4:0]  packet_index = '0;
  logic [5:0]  packet_total = '0;
  logic        out_stall    = 1'b0;
  logic        hold_off_req = 1'b0;
  logic        quiet        = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic        complete;
  logic [1:0]  status;
  logic [7:0]  done_app_id;
  logic [23:0] done_source_id;
  logic [31:0] done_msg_id;

  int unsigned results_owed;
  int unsigned mismatches;
  int unsigned target_open = TableEntries;

  // Messages the stimulus has started and not yet finished
  open_msg_t   open_msgs[$];

  packet_reassembly_tracker #(
    .TABLE_ENTRIES (TableEntries),
    .MAX_PACKETS   (MaxPackets)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .app_id_i         (app_id),
    .source_id_i      (source_id),
    .msg_id_i         (msg_id),
    .packet_index_i   (packet_index),
    .packet_total_i   (packet_total),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .complete_o       (complete),
    .status_o         (status),
    .done_app_id_o    (done_app_id),
    .done_source_id_o (done_source_id),
    .done_msg_id_o    (done_msg_id)
  );

  reassembly_checker #(
    .TABLE_ENTRIES (TableEntries),
    .MAX_PACKETS   (MaxPackets)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .app_id_i         (app_id),
    .source_id_i      (source_id),
    .msg_id_i         (msg_id),
    .packet_index_i   (packet_index),
    .packet_total_i   (packet_total),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .complete_i       (complete),
    .status_i         (status),
    .done_app_id_i    (done_app_id),
    .done_source_id_i (done_source_id),
    .done_msg_id_i    (done_msg_id),
    .results_owed_o   (results_owed),
    .mismatches_o     (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one; none at all in quiet phases
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(21, 60);
  endfunction

  function automatic int open_index(logic [63:0] key);
    foreach (open_msgs[i]) begin
      if (open_msgs[i].key == key) return i;
    end
    return -1;
  endfunction

  // Random key not in flight, sometimes one bit away from an open message
  function automatic logic [63:0] fresh_key();
    logic [63:0] k;
    do begin
      k = {$urandom, $urandom};
      if (open_msgs.size() > 0 && $urandom_range(0, 3) == 0)
        k = open_msgs[$urandom_range(0, open_msgs.size() - 1)].key ^
            (64'd1 << $urandom_range(0, 63));
    end while (open_index(k) >= 0);
    return k;
  endfunction

  function automatic logic [5:0] pick_total();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 6'($urandom_range(1, 3));
    if (r < 85) return 6'($urandom_range(4, 8));
    if (r < 97) return 6'($urandom_range(9, 20));
    return 6'($urandom_range(21, MaxPackets));
  endfunction

  // Find an index below total whose sent bit equals want, starting at random
  function automatic logic [4:0] pick_index(logic [31:0] sent, logic [5:0] total, logic want);
    int unsigned start;
    int unsigned j;
    start = $urandom_range(0, total - 1);
    for (int unsigned i = 0; i < total; i++) begin
      j = (start + i) % total;
      if (sent[j] == want) return 5'(j);
    end
    return 5'(start);
  endfunction

  // Track which messages occupy the table so the stimulus can aim at hits and a full table
  function automatic void note_packet(logic [63:0] key, logic [4:0] idx, logic [5:0] tot);
    open_msg_t m;
    int        pos;
    pos = open_index(key);
    if (pos >= 0) begin
      m = open_msgs[pos];
      if (idx < m.total && !m.sent[idx]) begin
        m.sent[idx] = 1'b1;
        m.left      = m.left - 1;
        if (m.left == 0) open_msgs.delete(pos);
        else open_msgs[pos] = m;
      end
    end else if (tot > 1 && tot <= MaxPackets && idx < tot &&
                 open_msgs.size() < TableEntries) begin
      m.key  = key;
      m.total = tot;
      m.sent = 32'd1 << idx;
      m.left = tot - 1;
      open_msgs.push_back(m);
    end
  endfunction

  // Present one request after a random gap and hold it until it is taken
  task automatic offer(input logic [63:0] key, input logic [4:0] idx, input logic [5:0] tot);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      {app_id, source_id, msg_id} <= {$urandom, $urandom};
      repeat (gap) @(posedge clk_i);
    end
    in_valid                    <= 1'b1;
    {app_id, source_id, msg_id} <= key;
    packet_index                <= idx;
    packet_total                <= tot;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    note_packet(key, idx, tot);
  endtask

  // Mostly well-formed message traffic, with duplicates, bad indexes and noise mixed in
  task automatic random_packet();
    open_msg_t   m;
    logic [63:0] key;
    logic [5:0]  tot;
    logic [4:0]  idx;
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = open_msgs.size();
    m = '0;
    if (n == 0) r = 0;
    else begin
      if (r < 30 && n >= target_open) r = 99;
      m = open_msgs[$urandom_range(0, n - 1)];
    end
    if (r < 34) begin
      // start a message; dropped when the table is full
      key = fresh_key();
      tot = pick_total();
      idx = 5'($urandom_range(0, tot - 1));
    end else if (r < 42) begin
      key = m.key;
      idx = pick_index(m.sent, m.total, 1'b1);
      tot = m.total;
    end else if (r < 48) begin
      if (m.total < MaxPackets && r[0]) begin
        key = m.key;
        idx = 5'($urandom_range(m.total, 31));
        tot = 6'($urandom);
      end else begin
        key = fresh_key();
        idx = 5'($urandom);
        case ($urandom_range(0, 2))
          0: tot = '0;
          1: tot = 6'($urandom_range(MaxPackets + 1, 63));
          default: begin
            tot = 6'($urandom_range(1, 31));
            idx = 5'($urandom_range(tot, 31));
          end
        endcase
      end
    end else if (r < 54) begin
      key = fresh_key();
      idx = 5'($urandom);
      tot = 6'($urandom);
    end else begin
      key = m.key;
      idx = pick_index(m.sent, m.total, 1'b0);
      tot = ($urandom_range(0, 7) == 0) ? 6'($urandom) : m.total;
    end
    offer(key, idx, tot);
  endtask

  // Drop valid and wait until every result owed has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (results_owed == 0);
    @(posedge clk_i);
  endtask

  // Result side: random stalls plus one long hold-off on request
  initial begin : result_side
    int unsigned run;
    logic        hold_off_done;
    hold_off_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      run = pick_gap();
      if (run > 0) begin
        out_stall <= 1'b1;
        repeat (run) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned span;
    int unsigned random_sent;
    logic [63:0] long_key;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-packet messages at both ends of the id ranges
    offer({8'hFF, 24'hFF_FFFF, 32'hFFFF_FFFF}, 5'd0, 6'd1);
    offer(64'd0, 5'd0, 6'd1);
    // malformed first packets: zero total, oversized total, index past total
    offer(64'h0123_4567_89AB_CDEF, 5'd0, 6'd0);
    offer(64'h0123_4567_89AB_CDEF, 5'd31, 6'd63);
    offer(64'h0123_4567_89AB_CDEF, 5'd4, 6'd4);
    // three-packet message with a duplicate and an index past the stored total
    offer(64'h7E_00C0DE_0000_0003, 5'd2, 6'd3);
    offer(64'h7E_00C0DE_0000_0003, 5'd2, 6'd3);
    offer(64'h7E_00C0DE_0000_0003, 5'd3, 6'd32);
    offer(64'h7E_00C0DE_0000_0003, 5'd0, 6'd3);
    offer(64'h7E_00C0DE_0000_0003, 5'd1, 6'd7);
    // longest message, first and last index, left open
    long_key = 64'hA5_5A5A5A_0000_0001;
    offer(long_key, 5'd31, 6'd32);
    offer(long_key, 5'd0, 6'd32);
    // same app and source, other message id: a separate entry
    offer(long_key ^ 64'd1, 5'd0, 6'd2);
    // fill the table, then a new message has nowhere to go
    while (open_msgs.size() < TableEntries) offer(fresh_key(), 5'd0, 6'd2);
    offer(fresh_key(), 5'd1, 6'd2);

    // random traffic in phases of varying table load and idling
    random_sent = 0;
    phase       = 0;
    while (random_sent < RandomItems) begin
      span        = $urandom_range(50, 250);
      quiet       = ($urandom_range(0, 4) == 0);
      target_open = ($urandom_range(0, 2) == 0) ? TableEntries
                                                : $urandom_range(1, TableEntries);
      if (phase == 2) hold_off_req <= 1'b1;
      repeat (span) begin
        random_packet();
        random_sent++;
      end
      if (phase == 4 || $urandom_range(0, 5) == 0) drain_results();
      phase++;
    end

    drain_results();
    repeat (2 * TableEntries + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Bound the run in case the block hangs
  initial begin : watchdog
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
